// ===== design/hrs_pkg.sv =====
// shared types, constants and character classes for the hostname run scanner
package hrs_pkg;

	localparam int POSITION_BITS  = 16;
	localparam int OFFSET_BITS    = 16;
	localparam int NAME_LEN_BITS  = 8;
	localparam int LABEL_LIM_BITS = 6;
	localparam int LABEL_LEN_BITS = 7;
	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 8;

	localparam logic [CFG_INDEX_BITS-1:0] CFG_MIN_NAME_LEN  = CFG_INDEX_BITS'(0);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_NAME_LEN  = CFG_INDEX_BITS'(1);
	localparam logic [CFG_INDEX_BITS-1:0] CFG_MAX_LABEL_LEN = CFG_INDEX_BITS'(2);

	localparam logic [NAME_LEN_BITS-1:0]  MIN_NAME_RESET  = NAME_LEN_BITS'(6);
	localparam logic [NAME_LEN_BITS-1:0]  MAX_NAME_RESET  = NAME_LEN_BITS'(253);
	localparam logic [LABEL_LIM_BITS-1:0] MAX_LABEL_RESET = LABEL_LIM_BITS'(63);

	localparam logic [NAME_LEN_BITS-1:0]  NAME_LEN_TOP  = '1;
	localparam logic [LABEL_LEN_BITS-1:0] LABEL_LEN_TOP = '1;

	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
	} item_t;

	typedef struct packed {
		logic [NAME_LEN_BITS-1:0]  min_name;
		logic [NAME_LEN_BITS-1:0]  max_name;
		logic [LABEL_LIM_BITS-1:0] max_label;
	} cfg_t;

	typedef struct packed {
		logic                     found;
		logic [OFFSET_BITS-1:0]   offset;
		logic [NAME_LEN_BITS-1:0] length;
	} result_t;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h41 && c <= 8'h5A);
	endfunction

	function automatic logic is_name_char(input logic [7:0] c);
		return is_letter(c) || (c >= 8'h30 && c <= 8'h39) || c == CHAR_DOT || c == CHAR_HYPHEN;
	endfunction

endpackage

// ===== design/hrs_in_reg.sv =====
// input register stage with valid/ready handshake
module hrs_in_reg (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  logic [7:0]    data_byte,
	input  logic          last_byte,
	input  logic          out_free,
	output logic          take,
	output hrs_pkg::item_t item_s1
);

	logic valid_s1;

	// a last byte needs room in the result register
	assign take     = valid_s1 && (!item_s1.last || out_free);
	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1.data <= data_byte;
			item_s1.last <= last_byte;
		end
	end

endmodule

// ===== design/hrs_scan.sv =====
// per-byte scan state and candidate judging
module hrs_scan (
	input  logic            clk,
	input  logic            arst_n,
	input  hrs_pkg::cfg_t   cfg,
	input  logic            take,
	input  hrs_pkg::item_t  item,
	output hrs_pkg::result_t result
);

	logic [hrs_pkg::POSITION_BITS-1:0]  pos_q, pos_next;
	logic                               active_q;
	logic [hrs_pkg::POSITION_BITS-1:0]  start_q;
	logic [hrs_pkg::NAME_LEN_BITS-1:0]  len_q;
	logic [hrs_pkg::LABEL_LEN_BITS-1:0] lab_q;
	logic                               laberr_q;
	logic                               seen_q;
	logic                               pdh_q;
	logic                               done_q;
	logic [hrs_pkg::POSITION_BITS-1:0]  fstart_q;
	logic [hrs_pkg::NAME_LEN_BITS-1:0]  flen_q;

	logic                               t_active;
	logic [hrs_pkg::POSITION_BITS-1:0]  t_start;
	logic [hrs_pkg::NAME_LEN_BITS-1:0]  t_len;
	logic [hrs_pkg::LABEL_LEN_BITS-1:0] t_lab;
	logic                               t_laberr;
	logic                               t_seen;
	logic                               t_pdh;

	logic letter, name_ch, dot, hyphen, pos_top;
	logic close_en, ok, accept;
	logic                               d_done;
	logic [hrs_pkg::POSITION_BITS-1:0]  d_fstart;
	logic [hrs_pkg::NAME_LEN_BITS-1:0]  d_flen;
	logic [hrs_pkg::LABEL_LEN_BITS-1:0] lab_limit;

	assign letter    = hrs_pkg::is_letter(item.data);
	assign name_ch   = hrs_pkg::is_name_char(item.data);
	assign dot       = item.data == hrs_pkg::CHAR_DOT;
	assign hyphen    = item.data == hrs_pkg::CHAR_HYPHEN;
	assign pos_top   = pos_q == '1;
	assign pos_next  = pos_top ? pos_q : pos_q + 1'b1;
	assign lab_limit = {1'b0, cfg.max_label};

	always_comb begin
		t_active = active_q;
		t_start  = start_q;
		t_len    = len_q;
		t_lab    = lab_q;
		t_laberr = laberr_q;
		t_seen   = seen_q;
		t_pdh    = pdh_q;
		if (!done_q) begin
			if (active_q) begin
				if (!name_ch) begin
					t_active = 1'b0;
				end else begin
					if (len_q <= cfg.max_name && len_q != hrs_pkg::NAME_LEN_TOP) begin
						t_len = len_q + 1'b1;
					end
					if (dot) begin
						t_seen = 1'b1;
						if (lab_q == '0 || lab_q > lab_limit) begin
							t_laberr = 1'b1;
						end
						t_lab = '0;
						t_pdh = 1'b1;
					end else begin
						if (lab_q != hrs_pkg::LABEL_LEN_TOP) begin
							t_lab = lab_q + 1'b1;
						end
						t_pdh = hyphen;
					end
				end
			end else if (letter && !pos_top) begin
				t_active = 1'b1;
				t_start  = pos_q;
				t_len    = hrs_pkg::NAME_LEN_BITS'(1);
				t_lab    = hrs_pkg::LABEL_LEN_BITS'(1);
				t_laberr = 1'b0;
				t_seen   = 1'b0;
				t_pdh    = 1'b0;
			end
		end
	end

	// run ends at a non-name byte or at the end of the buffer
	assign close_en = !done_q && ((active_q && !name_ch) || (item.last && t_active));
	assign ok = t_len >= cfg.min_name && t_len <= cfg.max_name
		&& t_len != hrs_pkg::NAME_LEN_TOP && t_seen && !t_pdh && !t_laberr
		&& t_lab != '0 && t_lab <= lab_limit;
	assign accept   = close_en && ok;
	assign d_done   = done_q || accept;
	assign d_fstart = accept ? t_start : fstart_q;
	assign d_flen   = accept ? t_len : flen_q;

	assign result.found  = d_done;
	assign result.offset = d_done ? hrs_pkg::OFFSET_BITS'(d_fstart) : '0;
	assign result.length = d_done ? d_flen : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			active_q <= 1'b0;
			start_q  <= '0;
			len_q    <= '0;
			lab_q    <= '0;
			laberr_q <= 1'b0;
			seen_q   <= 1'b0;
			pdh_q    <= 1'b0;
			done_q   <= 1'b0;
			fstart_q <= '0;
			flen_q   <= '0;
		end else if (take) begin
			if (item.last) begin
				pos_q    <= '0;
				active_q <= 1'b0;
				start_q  <= '0;
				len_q    <= '0;
				lab_q    <= '0;
				laberr_q <= 1'b0;
				seen_q   <= 1'b0;
				pdh_q    <= 1'b0;
				done_q   <= 1'b0;
				fstart_q <= '0;
				flen_q   <= '0;
			end else begin
				pos_q    <= pos_next;
				active_q <= t_active && !accept;
				start_q  <= t_start;
				len_q    <= t_len;
				lab_q    <= t_lab;
				laberr_q <= t_laberr;
				seen_q   <= t_seen;
				pdh_q    <= t_pdh;
				done_q   <= d_done;
				fstart_q <= d_fstart;
				flen_q   <= d_flen;
			end
		end
	end

`ifndef ASSERT_OFF
	a_active_len: assert property (@(posedge clk) disable iff (!arst_n)
		active_q |-> len_q != '0)
		else $error("running candidate with zero length");

	a_found_len: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (flen_q != '0 && !active_q))
		else $error("found hostname with zero length or candidate still running");

	a_pos_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!take |=> $stable(pos_q))
		else $error("position moved without a byte");
`endif

endmodule

// ===== design/hrs_out_reg.sv =====
// result register with valid/ready handshake
module hrs_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  hrs_pkg::result_t result_in,
	output logic             out_free,
	output logic             out_valid,
	input  logic             out_ready,
	output hrs_pkg::result_t result_q
);

	logic out_valid_q;

	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			result_q <= result_in;
		end
	end

`ifndef ASSERT_OFF
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> out_free)
		else $error("result register overwritten while stalled");
`endif

endmodule

// ===== design/hostname_run_scanner_core.sv =====
// Usage notes:
// Input channel in_valid/in_ready carries one buffer byte per transaction in data_byte,
// with last_byte high on the final buffer byte. Takes one byte per cycle unless stalled.
// Output channel out_valid/out_ready carries one transaction per buffer, produced on
// its last byte: found, host_offset (offset of the first hostname byte) and host_length,
// both zero when nothing was found. Other bytes produce no transaction.
// After the last byte's transaction is accepted, the byte sits in the input register,
// then the single-pass scan logic loads the result into the result register.
// Throughput: one byte per cycle unless stalled, set by the single per-byte state update.
// Config: cfg_we with cfg_index 0 min name length, 1 max name length, 2 max label
// length, written while idle. Reset values are 6, 253 and 63.
// Reset clears all scan state, empties both registers and restores the config.
// When the receiver stalls, a finished result waits in the result register; bytes that
// are not last keep flowing, and a following last byte waits in the input register
// until the result has been taken.
module hostname_run_scanner_core (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [7:0]                         data_byte,
	input  logic                               last_byte,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic                               found,
	output logic [hrs_pkg::OFFSET_BITS-1:0]    host_offset,
	output logic [hrs_pkg::NAME_LEN_BITS-1:0]  host_length,
	input  logic                               cfg_we,
	input  logic [hrs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [hrs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

	hrs_pkg::cfg_t    cfg_q;
	hrs_pkg::item_t   item_s1;
	hrs_pkg::result_t scan_result;
	hrs_pkg::result_t result_q;
	logic             take;
	logic             out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_name  <= hrs_pkg::MIN_NAME_RESET;
			cfg_q.max_name  <= hrs_pkg::MAX_NAME_RESET;
			cfg_q.max_label <= hrs_pkg::MAX_LABEL_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				hrs_pkg::CFG_MIN_NAME_LEN: begin
					cfg_q.min_name <= hrs_pkg::NAME_LEN_BITS'(cfg_data);
				end
				hrs_pkg::CFG_MAX_NAME_LEN: begin
					cfg_q.max_name <= hrs_pkg::NAME_LEN_BITS'(cfg_data);
				end
				hrs_pkg::CFG_MAX_LABEL_LEN: begin
					cfg_q.max_label <= cfg_data[hrs_pkg::LABEL_LIM_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	hrs_in_reg u_in_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.last_byte (last_byte),
		.out_free  (out_free),
		.take      (take),
		.item_s1   (item_s1)
	);

	hrs_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.take   (take),
		.item   (item_s1),
		.result (scan_result)
	);

	hrs_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (take && item_s1.last),
		.result_in (scan_result),
		.out_free  (out_free),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.result_q  (result_q)
	);

	assign found       = result_q.found;
	assign host_offset = result_q.offset;
	assign host_length = result_q.length;

endmodule
